// File: sv/wmv_pkg.sv
package wmv_pkg;

   // Default build: a 16-entry window of 16-bit samples
   localparam int WMV_DEPTH_DEF       = 16;
   localparam int WMV_SAMPLE_BITS_DEF = 16;

   // Configuration port geometry
   localparam int WMV_CSR_DATA_BITS = 32;
   localparam int WMV_CSR_ADDR_BITS = 3;

   // Register index of the window length
   localparam int WMV_REG_WINDOW_LENGTH = 0;

   // Request opcodes carried on the mode field
   typedef enum logic [0:0] {
      MODE_APPEND = 1'b0,
      MODE_CLEAR  = 1'b1
   } mode_type;

endpackage

// File: sv/window_mean_variance.sv
// A clear is answered in the cycle after acceptance. An append is answered after two passes
//   over the sample RAM and a restoring divider that yields one quotient bit per cycle.
// One request at a time: req_stall holds until the response is taken.
// Reset (synchronous, active high) empties the window, sets the length to the window depth
//   and idles the sequencer; sample RAM contents are not cleared.
module window_mean_variance #(
   parameter int WINDOW_DEPTH = wmv_pkg::WMV_DEPTH_DEF,
   parameter int SAMPLE_BITS  = wmv_pkg::WMV_SAMPLE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_mode,
   input  logic signed [SAMPLE_BITS-1:0]             req_sample,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]         rsp_fill_count,
   output logic signed [SAMPLE_BITS-1:0]             rsp_average,
   output logic [2*SAMPLE_BITS-1:0]                  rsp_variance,
   // configuration port
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [wmv_pkg::WMV_CSR_ADDR_BITS-1:0]     paddr,
   input  logic [wmv_pkg::WMV_CSR_DATA_BITS-1:0]     pwdata,
   output logic [wmv_pkg::WMV_CSR_DATA_BITS-1:0]     prdata,
   output logic                                      pready
);

   import wmv_pkg::*;

   // Widths
   localparam int SB   = SAMPLE_BITS;
   localparam int CB   = $clog2(WINDOW_DEPTH + 1);          // fill count, length
   localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUMW = SB + CB;                           // signed window sum
   localparam int SQW  = 2 * SB + CB;                       // sum of squared deviations
   localparam int DW   = SQW;                               // divider dividend width
   localparam int DCW  = $clog2(DW + 1);                    // divider step counter
   localparam int RW   = CB + 1;                            // shifted partial remainder
   localparam int REGW = WMV_CSR_ADDR_BITS - 2;             // register index bits
   localparam int DB   = WMV_CSR_DATA_BITS;

   // Sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SUM     = 3'd1;
   localparam logic [2:0] ST_DIV_AVG = 3'd2;
   localparam logic [2:0] ST_SQ      = 3'd3;
   localparam logic [2:0] ST_DIV_VAR = 3'd4;
   localparam logic [2:0] ST_OUT     = 3'd5;

   logic [2:0]          state_ff,     state_in;
   logic [CB-1:0]       len_ff,       len_in;
   logic [AW-1:0]       wpos_ff,      wpos_in;
   logic [CB-1:0]       vcount_ff,    vcount_in;
   logic [CB-1:0]       cnt_ff,       cnt_in;
   logic                rd_pend_ff,   rd_pend_in;
   logic                prod_vld_ff,  prod_vld_in;
   logic [2*SB-1:0]     prod_ff,      prod_in;
   logic [SUMW-1:0]     sum_ff,       sum_in;
   logic [SQW-1:0]      sq_ff,        sq_in;
   logic [SB-1:0]       avg_ff,       avg_in;
   logic [DW-1:0]       dvd_ff,       dvd_in;
   logic [CB-1:0]       rem_ff,       rem_in;
   logic [DCW-1:0]      div_cnt_ff,   div_cnt_in;
   logic [CB-1:0]       out_fill_ff,  out_fill_in;
   logic [SB-1:0]       out_avg_ff,   out_avg_in;
   logic [2*SB-1:0]     out_var_ff,   out_var_in;

   // Combinational helpers
   logic                req_accept;
   logic                rsp_accept;
   logic                csr_write;
   logic                csr_hit;
   logic [CB-1:0]       eff_len;
   logic [AW-1:0]       wr_pos;
   logic [CB-1:0]       next_pos;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [SB-1:0]       ram_rd_data;
   logic [SB:0]         diff;
   logic [SB:0]         diff_mag;
   logic [2*SB-1:0]     prod;
   logic [SUMW-1:0]     abs_sum;
   logic [RW-1:0]       rem_sh;
   logic [RW-1:0]       rem_sub;
   logic                q_bit;
   logic                read_done;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // ---------------------------------------------------------------------------------------
   // Configuration: one register, the window length; any byte within its word hits it.
   // ---------------------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[WMV_CSR_ADDR_BITS-1:2] == REGW'(WMV_REG_WINDOW_LENGTH));
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = DB'(len_ff);
      end
   end

   // Clamp the programmed length into 1..WINDOW_DEPTH.
   always_comb begin
      priority if (len_ff == '0) begin
         eff_len = CB'(1);
      end else if (len_ff > CB'(WINDOW_DEPTH)) begin
         eff_len = CB'(WINDOW_DEPTH);
      end else begin
         eff_len = len_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Circular write pointer: wrap a stale position first (length may have shrunk), then
   // advance past the written slot and wrap again at the window length.
   // ---------------------------------------------------------------------------------------
   assign wr_pos   = (CB'(wpos_ff) >= eff_len) ? '0 : wpos_ff;
   assign next_pos = CB'(wr_pos) + CB'(1);

   // ---------------------------------------------------------------------------------------
   // Sample store. Both passes walk entries 0 .. fill-1 through the one read port; data
   // comes back in the cycle after the address is issued.
   // ---------------------------------------------------------------------------------------
   assign ram_wr_en = req_accept && (req_mode == MODE_APPEND);
   assign ram_rd_en = ((state_ff == ST_SUM) || (state_ff == ST_SQ)) && (cnt_ff < vcount_ff);
   assign read_done = (cnt_ff == vcount_ff) && !rd_pend_ff;

   wmv_ram #(
      .WIDTH (SB),
      .DEPTH (WINDOW_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_pos),
      .wr_data (req_sample),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Deviation from the average and its square (one S x S multiplier, registered).
   assign diff     = {ram_rd_data[SB-1], ram_rd_data} - {avg_ff[SB-1], avg_ff};
   assign diff_mag = diff[SB] ? (~diff + 1'b1) : diff;
   assign prod     = diff_mag[SB-1:0] * diff_mag[SB-1:0];

   // Magnitude of the window sum; the sign is kept in sum_ff for the final negate.
   assign abs_sum = sum_ff[SUMW-1] ? (~sum_ff + 1'b1) : sum_ff;

   // One restoring-division step: shift in the next dividend bit, subtract if it fits.
   assign rem_sh  = {rem_ff, dvd_ff[DW-1]};
   assign q_bit   = (rem_sh >= RW'(vcount_ff));
   assign rem_sub = q_bit ? (rem_sh - RW'(vcount_ff)) : rem_sh;

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      wpos_in     = wpos_ff;
      vcount_in   = vcount_ff;
      cnt_in      = cnt_ff;
      rd_pend_in  = ram_rd_en;
      prod_vld_in = 1'b0;
      prod_in     = prod_ff;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      avg_in      = avg_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      out_fill_in = out_fill_ff;
      out_avg_in  = out_avg_ff;
      out_var_in  = out_var_ff;

      if (csr_write) begin
         len_in = pwdata[CB-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_CLEAR) begin
                  // Drop the window; stored samples stay but are no longer counted.
                  vcount_in   = '0;
                  wpos_in     = '0;
                  out_fill_in = '0;
                  out_avg_in  = '0;
                  out_var_in  = '0;
                  state_in    = ST_OUT;
               end else begin
                  wpos_in   = (next_pos >= eff_len) ? '0 : next_pos[AW-1:0];
                  vcount_in = (vcount_ff < eff_len) ? (vcount_ff + CB'(1)) : vcount_ff;
                  cnt_in    = '0;
                  sum_in    = '0;
                  state_in  = ST_SUM;
               end
            end
         end

         ST_SUM: begin
            // Issue reads, accumulate the sign-extended samples as they return.
            if (ram_rd_en) begin
               cnt_in = cnt_ff + CB'(1);
            end
            if (rd_pend_ff) begin
               sum_in = sum_ff + {{(SUMW-SB){ram_rd_data[SB-1]}}, ram_rd_data};
            end
            if (read_done) begin
               dvd_in     = {abs_sum, {(DW-SUMW){1'b0}}};
               rem_in     = '0;
               div_cnt_in = DCW'(SUMW);
               state_in   = ST_DIV_AVG;
            end
         end

         ST_DIV_AVG: begin
            if (div_cnt_ff != '0) begin
               dvd_in     = {dvd_ff[DW-2:0], q_bit};
               rem_in     = rem_sub[CB-1:0];
               div_cnt_in = div_cnt_ff - DCW'(1);
            end else begin
               // Truncate toward zero: divide the magnitude, then restore the sign.
               avg_in   = sum_ff[SUMW-1] ? (~dvd_ff[SB-1:0] + 1'b1) : dvd_ff[SB-1:0];
               cnt_in   = '0;
               sq_in    = '0;
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            // Read, square the deviation into prod_ff, then accumulate.
            if (ram_rd_en) begin
               cnt_in = cnt_ff + CB'(1);
            end
            prod_vld_in = rd_pend_ff;
            if (rd_pend_ff) begin
               prod_in = prod;
            end
            if (prod_vld_ff) begin
               sq_in = sq_ff + SQW'(prod_ff);
            end
            if (read_done && !prod_vld_ff) begin
               dvd_in     = sq_ff;
               rem_in     = '0;
               div_cnt_in = DCW'(DW);
               state_in   = ST_DIV_VAR;
            end
         end

         ST_DIV_VAR: begin
            if (div_cnt_ff != '0) begin
               dvd_in     = {dvd_ff[DW-2:0], q_bit};
               rem_in     = rem_sub[CB-1:0];
               div_cnt_in = div_cnt_ff - DCW'(1);
            end else begin
               out_fill_in = vcount_ff;
               out_avg_in  = avg_ff;
               out_var_in  = dvd_ff[2*SB-1:0];
               state_in    = ST_OUT;
            end
         end

         ST_OUT: begin
            // Hold the response until the consumer takes it.
            if (rsp_accept) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         len_ff      <= CB'(WINDOW_DEPTH);
         wpos_ff     <= '0;
         vcount_ff   <= '0;
         cnt_ff      <= '0;
         rd_pend_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         wpos_ff     <= wpos_in;
         vcount_ff   <= vcount_in;
         cnt_ff      <= cnt_in;
         rd_pend_ff  <= rd_pend_in;
         prod_vld_ff <= prod_vld_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      sq_ff       <= sq_in;
      avg_ff      <= avg_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      out_fill_ff <= out_fill_in;
      out_avg_ff  <= out_avg_in;
      out_var_ff  <= out_var_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_fill_count = out_fill_ff;
   assign rsp_average    = out_avg_ff;
   assign rsp_variance   = out_var_ff;

   // ---------------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------------
   a_no_accept_while_busy : assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("request port open while a response is pending");

   a_fill_in_range : assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= CB'(WINDOW_DEPTH))
      else $error("fill count exceeds window depth");

   a_clear_answers_empty : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_mode == MODE_CLEAR)) |=>
         (rsp_valid && (rsp_fill_count == '0) && (rsp_variance == '0)))
      else $error("clear did not produce an empty response");

   a_resp_fill_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count == vcount_ff))
      else $error("response fill count differs from window state");

endmodule

// File: sv/wmv_ram.sv
module wmv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
